// ===== hdl/csvclp_pkg.sv =====
// shared types and constants for the serial command line parser
`default_nettype none
package csvclp_pkg;

	localparam int unsigned FRACTION_DIGITS = 5;
	localparam int unsigned FRACTION_BITS   = 14;

	localparam int unsigned FRAC_W   = 17;
	localparam int unsigned FCNT_W   = 3;
	localparam int unsigned NUM_W    = FRAC_W + FRACTION_BITS;
	localparam int unsigned DIV_SHIFT = 5;
	localparam int unsigned NHI_W    = NUM_W - DIV_SHIFT;
	localparam int unsigned RECIP_W  = 27;
	localparam int unsigned PROD_W   = NHI_W + RECIP_W;
	localparam int unsigned RECIP_SHIFT = 38;
	localparam int unsigned MAG_W    = 15;
	localparam int unsigned FIX_W    = 16;

	// value / 10^5 as (value >> 5) * ceil(2^38 / 3125) >> 38
	localparam logic [RECIP_W-1:0] RECIP      = 27'd87960931;
	localparam logic [NUM_W-1:0]   ROUND_HALF = 31'd50000;
	localparam logic [MAG_W-1:0]   FIX_ONE    = 15'd16384;
	localparam logic [FCNT_W-1:0]  FCNT_MAX   = 3'd5;

	localparam logic [7:0] CH_NUL   = 8'h00;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_LF    = 8'h0A;
	localparam logic [7:0] CH_VT    = 8'h0B;
	localparam logic [7:0] CH_FF    = 8'h0C;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_PLUS  = 8'h2B;
	localparam logic [7:0] CH_COMMA = 8'h2C;
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_POINT = 8'h2E;
	localparam logic [7:0] CH_0     = 8'h30;
	localparam logic [7:0] CH_9     = 8'h39;

	localparam logic [1:0] SLOT_THROTTLE = 2'd0;
	localparam logic [1:0] SLOT_TURN     = 2'd1;
	localparam logic [1:0] SLOT_ENABLE   = 2'd2;
	localparam logic [1:0] SLOT_FULL     = 2'd3;

	typedef enum logic [2:0] {
		PH_BETWEEN,
		PH_BLANKS,
		PH_SIGNED,
		PH_INT,
		PH_POINT,
		PH_FRAC,
		PH_DONE
	} phase_t;

	typedef struct packed {
		logic              tok_wr;
		logic [1:0]        slot;
		logic              neg;
		logic              int_nz;
		logic              nz;
		logic              line_end;
		logic              ok;
	} evt_t;

	// place value of the next kept fraction digit
	function automatic logic [FRAC_W-1:0] frac_weight(input logic [FCNT_W-1:0] pos);
		logic [FRAC_W-1:0] w;
		case (pos)
			3'd0: w = 17'd10000;
			3'd1: w = 17'd1000;
			3'd2: w = 17'd100;
			3'd3: w = 17'd10;
			3'd4: w = 17'd1;
			default: w = '0;
		endcase
		return w;
	endfunction

endpackage
`default_nettype wire

// ===== hdl/csv_command_line_parser_top.sv =====
// serial command line parser: bytes in, one command result per non-empty line out
//
// Takes one received byte per cycle on the slave stream while s_tready is high, and
// parses lines of the form throttle,turn,enable. Every byte, including a line end,
// can be taken in consecutive cycles; the per-byte token state update is the only
// loop. A line ending in CR or LF gives one result on the master stream once its
// line end byte has passed the input register, the token register, a reciprocal
// multiply register that turns the decimal fraction into Q1.14, and the result
// register. Input keeps flowing while a result waits, and only pauses while a
// second line result is ready for the output register before the first is taken.
`default_nettype none
module csv_command_line_parser_top
	import csvclp_pkg::*;
#(
	parameter int unsigned LINE_BYTES = 64
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [7:0]  s_tdata,  // rx_byte[7:0]
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [39:0]      m_tdata   // line_ok, throttle[15:0], turn[15:0], enabled, zero pad
);

	localparam int unsigned LEN_W = $clog2(LINE_BYTES);
	localparam logic [LEN_W-1:0] LEN_LAST = LEN_W'(LINE_BYTES - 1);

	// input register
	logic       valid_s1;
	logic [7:0] byte_s1;

	// token state
	phase_t             phase_q, phase_n;
	logic [LEN_W-1:0]   len_q, len_n;
	logic [1:0]         cnt_q, cnt_n;
	logic               neg_q, neg_n;
	logic               int_nz_q, int_nz_n;
	logic [FRAC_W-1:0]  frac_q, frac_n;
	logic [FCNT_W-1:0]  fcnt_q, fcnt_n;
	logic               nz_q, nz_n;
	logic               ended_q, ended_n;

	// token events
	evt_t              evt;
	logic              push;
	logic              valid_s2;
	evt_t              evt_s2;
	logic [FRAC_W-1:0] frac_s2;
	logic              valid_s3;
	evt_t              evt_s3;
	logic [PROD_W-1:0] prod_s3;

	// command registers
	logic [FIX_W-1:0] pend_thr_q, pend_turn_q;
	logic             pend_en_q;
	logic [FIX_W-1:0] held_thr_q, held_turn_q;
	logic             held_en_q;

	logic        out_valid_q;
	logic [39:0] out_data_q;

	logic stall, advance;

	logic                is_digit, early, tok_open, tok_take;
	logic [3:0]          digit;
	logic [FRAC_W+3:0]   dig_term;
	logic [NUM_W-1:0]    num;
	logic [PROD_W-1:0]   prod;
	logic [MAG_W-1:0]    quot, mag;
	logic [FIX_W-1:0]    fixed;
	logic [FIX_W-1:0]    thr_m, turn_m;
	logic                en_m;

	assign stall    = valid_s3 && evt_s3.line_end && out_valid_q && !m_tready;
	assign advance  = !stall;
	assign s_tready = advance;
	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;

	// per-byte parse
	always_comb begin
		phase_n  = phase_q;
		len_n    = len_q;
		cnt_n    = cnt_q;
		neg_n    = neg_q;
		int_nz_n = int_nz_q;
		frac_n   = frac_q;
		fcnt_n   = fcnt_q;
		nz_n     = nz_q;
		ended_n  = ended_q;
		push     = 1'b0;

		is_digit = (byte_s1 >= CH_0) && (byte_s1 <= CH_9);
		digit    = byte_s1[3:0];
		early    = (phase_q == PH_BETWEEN) || (phase_q == PH_BLANKS);
		tok_open = phase_q != PH_BETWEEN;
		tok_take = tok_open && (cnt_q != SLOT_FULL);
		dig_term = {4'b0, frac_weight(fcnt_q)} * {{FRAC_W{1'b0}}, digit};

		evt          = '0;
		evt.slot     = cnt_q;
		evt.neg      = neg_q;
		evt.int_nz   = int_nz_q;
		evt.nz       = nz_q;

		if (valid_s1) begin
			if (byte_s1 == CH_LF || byte_s1 == CH_CR) begin
				if (len_q != '0) begin
					push         = 1'b1;
					evt.line_end = 1'b1;
					evt.tok_wr   = tok_take;
					evt.ok       = (cnt_q == SLOT_FULL) || (cnt_q == SLOT_ENABLE && tok_open);
					phase_n  = PH_BETWEEN;
					len_n    = '0;
					cnt_n    = '0;
					neg_n    = 1'b0;
					int_nz_n = 1'b0;
					frac_n   = '0;
					fcnt_n   = '0;
					nz_n     = 1'b0;
					ended_n  = 1'b0;
				end
			end else if (len_q >= LEN_LAST) begin
				// overflow: drop the line parsed so far
				phase_n  = PH_BETWEEN;
				len_n    = '0;
				cnt_n    = '0;
				neg_n    = 1'b0;
				int_nz_n = 1'b0;
				frac_n   = '0;
				fcnt_n   = '0;
				nz_n     = 1'b0;
				ended_n  = 1'b0;
			end else begin
				len_n = len_q + 1'b1;
				if (!ended_q) begin
					if (byte_s1 == CH_NUL) begin
						ended_n = 1'b1;
					end else if (byte_s1 == CH_COMMA) begin
						if (tok_take) begin
							push       = 1'b1;
							evt.tok_wr = 1'b1;
							cnt_n      = cnt_q + 1'b1;
						end
						phase_n  = PH_BETWEEN;
						neg_n    = 1'b0;
						int_nz_n = 1'b0;
						frac_n   = '0;
						fcnt_n   = '0;
						nz_n     = 1'b0;
					end else if (phase_q != PH_DONE) begin
						if (is_digit) begin
							if (digit != 4'd0) begin
								nz_n = 1'b1;
							end
							if (phase_q == PH_POINT || phase_q == PH_FRAC) begin
								phase_n = PH_FRAC;
								if (fcnt_q < FCNT_MAX) begin
									frac_n = frac_q + FRAC_W'(dig_term);
									fcnt_n = fcnt_q + 1'b1;
								end
							end else begin
								phase_n = PH_INT;
								if (digit != 4'd0) begin
									int_nz_n = 1'b1;
								end
							end
						end else if (byte_s1 == CH_POINT) begin
							if (early || phase_q == PH_SIGNED) begin
								phase_n = PH_POINT;
							end else if (phase_q == PH_INT) begin
								phase_n = PH_FRAC;
							end else begin
								phase_n = PH_DONE;
							end
						end else if (byte_s1 == CH_PLUS || byte_s1 == CH_MINUS) begin
							if (early) begin
								neg_n   = byte_s1 == CH_MINUS;
								phase_n = PH_SIGNED;
							end else begin
								phase_n = PH_DONE;
							end
						end else if (byte_s1 == CH_SPACE || byte_s1 == CH_TAB
								|| byte_s1 == CH_VT || byte_s1 == CH_FF) begin
							phase_n = early ? PH_BLANKS : PH_DONE;
						end else begin
							phase_n = PH_DONE;
						end
					end
				end
			end
		end
	end

	// fraction to q1.14: round(frac * 2^14 / 10^5)
	always_comb begin
		num  = {frac_s2, {FRACTION_BITS{1'b0}}} + ROUND_HALF;
		prod = {{RECIP_W{1'b0}}, num[NUM_W-1:DIV_SHIFT]} * {{NHI_W{1'b0}}, RECIP};
	end

	// finish the token and merge into the pending command
	always_comb begin
		quot  = prod_s3[RECIP_SHIFT +: MAG_W];
		mag   = (evt_s3.int_nz || quot > FIX_ONE) ? FIX_ONE : quot;
		fixed = evt_s3.neg ? FIX_W'(-{1'b0, mag}) : {1'b0, mag};
		thr_m  = (evt_s3.tok_wr && evt_s3.slot == SLOT_THROTTLE) ? fixed : pend_thr_q;
		turn_m = (evt_s3.tok_wr && evt_s3.slot == SLOT_TURN) ? fixed : pend_turn_q;
		en_m   = (evt_s3.tok_wr && evt_s3.slot == SLOT_ENABLE) ? evt_s3.nz : pend_en_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			phase_q  <= PH_BETWEEN;
			len_q    <= '0;
			cnt_q    <= '0;
			neg_q    <= 1'b0;
			int_nz_q <= 1'b0;
			frac_q   <= '0;
			fcnt_q   <= '0;
			nz_q     <= 1'b0;
			ended_q  <= 1'b0;
			held_thr_q  <= '0;
			held_turn_q <= '0;
			held_en_q   <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (advance) begin
				valid_s1 <= s_tvalid;
				phase_q  <= phase_n;
				len_q    <= len_n;
				cnt_q    <= cnt_n;
				neg_q    <= neg_n;
				int_nz_q <= int_nz_n;
				frac_q   <= frac_n;
				fcnt_q   <= fcnt_n;
				nz_q     <= nz_n;
				ended_q  <= ended_n;
				valid_s2 <= push;
				valid_s3 <= valid_s2;
				if (valid_s3 && evt_s3.line_end && evt_s3.ok) begin
					held_thr_q  <= thr_m;
					held_turn_q <= turn_m;
					held_en_q   <= en_m;
				end
			end
			if (advance && valid_s3 && evt_s3.line_end) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (advance) begin
			byte_s1 <= s_tdata;
			evt_s2  <= evt;
			frac_s2 <= frac_q;
			evt_s3  <= evt_s2;
			prod_s3 <= prod;
			if (valid_s3) begin
				pend_thr_q  <= thr_m;
				pend_turn_q <= turn_m;
				pend_en_q   <= en_m;
			end
			if (valid_s3 && evt_s3.line_end) begin
				if (evt_s3.ok) begin
					out_data_q <= {6'b0, en_m, turn_m, thr_m, 1'b1};
				end else begin
					out_data_q <= {6'b0, held_en_q, held_turn_q, held_thr_q, 1'b0};
				end
			end
		end
	end

endmodule
`default_nettype wire
